>>> sv/kcl_pkg.sv
package kcl_pkg;

    parameter int CODE_LEN_DEF = 6;
    parameter int MAX_CODE_LEN = 12;
    parameter int NIB_W        = 4;
    parameter int SECRET_W     = 24;
    parameter int ECHO_W       = 14;
    parameter int PADDR_W      = 3;
    parameter int PDATA_W      = 32;

    parameter logic [SECRET_W-1:0] SECRET_RST = 24'h123456;
    parameter logic [ECHO_W-1:0]   LIMIT_RST  = 14'd588;

    // register select: paddr[2]
    parameter logic REG_SECRET = 1'b0;
    parameter logic REG_LIMIT  = 1'b1;

    parameter logic OP_KEY  = 1'b0;
    parameter logic OP_ECHO = 1'b1;

    parameter logic [3:0] KEY_STAR = 4'd10;
    parameter logic [3:0] KEY_HASH = 4'd11;

    parameter logic [1:0] LOCK_LOCKED = 2'd0;
    parameter logic [1:0] LOCK_OPEN   = 2'd1;
    parameter logic [1:0] LOCK_ALERT  = 2'd2;

    parameter logic [2:0] SND_NONE    = 3'd0;
    parameter logic [2:0] SND_SUCCESS = 3'd1;
    parameter logic [2:0] SND_ERROR   = 3'd2;
    parameter logic [2:0] SND_CLOSE   = 3'd3;
    parameter logic [2:0] SND_ALERT   = 3'd4;

    typedef enum logic [2:0] {
        MODE_LOCKED = 3'b001,
        MODE_OPEN   = 3'b010,
        MODE_ALERT  = 3'b100
    } mode_t;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        key_code;
        logic [ECHO_W-1:0] echo_us;
    } kcl_evt_t;

    typedef struct packed {
        logic [1:0] lock_mode;
        logic [2:0] digit_count;
        logic [2:0] sound_event;
        logic       refresh;
    } kcl_sts_t;

endpackage

>>> sv/kcl_cfg.sv
module kcl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcl_pkg::PADDR_W-1:0]    paddr,
    input  logic [kcl_pkg::PDATA_W-1:0]    pwdata,
    output logic [kcl_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [kcl_pkg::SECRET_W-1:0]   secret_code,
    output logic [kcl_pkg::ECHO_W-1:0]     open_limit_us
);
    import kcl_pkg::*;

    logic [SECRET_W-1:0] secret_reg;
    logic [ECHO_W-1:0]   limit_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_reg <= SECRET_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SECRET)
            begin
                secret_reg <= pwdata[SECRET_W-1:0];
            end
            else
            begin
                limit_reg <= pwdata[ECHO_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SECRET: prdata = PDATA_W'(secret_reg);
            REG_LIMIT:  prdata = PDATA_W'(limit_reg);
            default:    prdata = '0;
        endcase
    end

    assign secret_code   = secret_reg;
    assign open_limit_us = limit_reg;

endmodule

>>> sv/kcl_in_reg.sv
module kcl_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  kcl_pkg::kcl_evt_t evt,
    input  logic              advance,
    output logic              s1_valid,
    output kcl_pkg::kcl_evt_t s1
);
    import kcl_pkg::*;

    logic     s1_valid_reg;
    kcl_evt_t s1_reg;

    assign evt_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt_ready)
        begin
            s1_valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            s1_reg <= evt;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

>>> sv/kcl_core.sv
module kcl_core #(
    parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    input  kcl_pkg::kcl_evt_t             s1,
    input  logic [kcl_pkg::SECRET_W-1:0]  secret_code,
    input  logic [kcl_pkg::ECHO_W-1:0]    open_limit_us,
    output logic                          advance,
    output logic                          sts_valid,
    input  logic                          sts_ready,
    output kcl_pkg::kcl_sts_t             sts
);
    import kcl_pkg::*;

    localparam int CW    = $clog2(CODE_LEN + 1);
    localparam int IW    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int EXT_W = NIB_W * MAX_CODE_LEN;

    mode_t             mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              opened_reg, opened_next;
    logic [NIB_W-1:0]  digits_reg [CODE_LEN];
    logic              sts_valid_reg;
    kcl_sts_t          sts_reg, sts_next;

    logic              take;
    logic              digit_we;
    logic [IW-1:0]     digit_idx;
    logic              code_ok;
    logic              door_open;
    logic [EXT_W-1:0]  code_ext;
    logic [2:0]        sound;
    logic              refresh;
    logic [1:0]        mode_code;

    assign advance   = !sts_valid_reg || sts_ready;
    assign take      = advance && s1_valid;
    assign digit_idx = count_reg[IW-1:0];
    assign door_open = s1.echo_us > open_limit_us;
    // positions past the six stored nibbles compare against zero
    assign code_ext  = EXT_W'(secret_code);

    always_comb
    begin
        code_ok = (count_reg == CW'(CODE_LEN));
        for (int i = 0; i < CODE_LEN; i++)
        begin
            if (digits_reg[i] != code_ext[NIB_W*(CODE_LEN-1-i) +: NIB_W])
            begin
                code_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        opened_next = opened_reg;
        digit_we    = 1'b0;
        sound       = SND_NONE;
        refresh     = 1'b0;
        if (s1.opcode == OP_KEY)
        begin
            priority if (s1.key_code < KEY_STAR)
            begin
                if (count_reg < CW'(CODE_LEN))
                begin
                    digit_we   = 1'b1;
                    count_next = CW'(count_reg + 1'b1);
                    refresh    = 1'b1;
                end
            end
            else if (s1.key_code == KEY_STAR)
            begin
                if (count_reg != '0)
                begin
                    count_next = CW'(count_reg - 1'b1);
                    refresh    = 1'b1;
                end
            end
            else if (s1.key_code == KEY_HASH)
            begin
                if (mode_reg != MODE_OPEN)
                begin
                    if (code_ok)
                    begin
                        mode_next = MODE_OPEN;
                        sound     = SND_SUCCESS;
                    end
                    else
                    begin
                        sound = SND_ERROR;
                    end
                    count_next = '0;
                    refresh    = 1'b1;
                end
            end
            else
            begin
                // letter keys change nothing
                refresh = 1'b0;
            end
        end
        else if (s1.echo_us != '0)
        begin
            unique case (mode_reg)
                MODE_LOCKED:
                begin
                    if (door_open)
                    begin
                        mode_next = MODE_ALERT;
                        refresh   = 1'b1;
                    end
                end
                MODE_OPEN:
                begin
                    if (door_open)
                    begin
                        if (!opened_reg)
                        begin
                            opened_next = 1'b1;
                            refresh     = 1'b1;
                        end
                    end
                    else if (opened_reg)
                    begin
                        mode_next   = MODE_LOCKED;
                        opened_next = 1'b0;
                        sound       = SND_CLOSE;
                        refresh     = 1'b1;
                    end
                end
                MODE_ALERT:
                begin
                    sound = SND_ALERT;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_next)
            MODE_LOCKED: mode_code = LOCK_LOCKED;
            MODE_OPEN:   mode_code = LOCK_OPEN;
            MODE_ALERT:  mode_code = LOCK_ALERT;
            default:     mode_code = LOCK_LOCKED;
        endcase
    end

    // digit_count wraps modulo 8 for long codes
    assign sts_next.lock_mode   = mode_code;
    assign sts_next.digit_count = 3'(count_next);
    assign sts_next.sound_event = sound;
    assign sts_next.refresh     = refresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LOCKED;
            count_reg     <= '0;
            opened_reg    <= 1'b0;
            sts_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                sts_valid_reg <= s1_valid;
            end
            if (take)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                opened_reg <= opened_next;
            end
        end
    end

    // digits above the count never decide the match, so stale entries are harmless
    always_ff @(posedge clk)
    begin
        if (take && digit_we)
        begin
            digits_reg[digit_idx] <= s1.key_code;
        end
        if (take)
        begin
            sts_reg <= sts_next;
        end
    end

    assign sts_valid = sts_valid_reg;
    assign sts       = sts_reg;

endmodule

>>> sv/keypad_code_lock_with_door_sensor.sv
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+-----------------------------------
// evt     | in  | evt_valid/evt_ready  | kcl_evt_t: opcode, key_code, echo_us
// sts     | out | sts_valid/sts_ready  | kcl_sts_t: lock_mode, digit_count,
//         |     |                      |   sound_event, refresh
// apb     | in  | psel/penable/pready  | paddr, pwdata, prdata (2 registers)
//
// One event per cycle sustained while sts_ready holds; each event passes the input
// register, then the status register that holds the updated lock state.
// Each event's state update is a single pass of parallel compares.
// rst_n is asynchronous: mode locked, no digits, door-opened flag clear,
// code 0x123456, open limit 588 us.
// A stalled status transfer stalls the input register; one more event is
// still taken while a finished status waits.
module keypad_code_lock_with_door_sensor #(
    parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         evt_valid,
    output logic                         evt_ready,
    input  kcl_pkg::kcl_evt_t            evt,
    output logic                         sts_valid,
    input  logic                         sts_ready,
    output kcl_pkg::kcl_sts_t            sts,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kcl_pkg::PADDR_W-1:0]  paddr,
    input  logic [kcl_pkg::PDATA_W-1:0]  pwdata,
    output logic [kcl_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import kcl_pkg::*;

    logic                s1_valid;
    kcl_evt_t            s1;
    logic                advance;
    logic [SECRET_W-1:0] secret_code;
    logic [ECHO_W-1:0]   open_limit_us;

    kcl_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .secret_code   (secret_code),
        .open_limit_us (open_limit_us)
    );

    kcl_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    kcl_core #(
        .CODE_LEN (CODE_LEN)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .secret_code   (secret_code),
        .open_limit_us (open_limit_us),
        .advance       (advance),
        .sts_valid     (sts_valid),
        .sts_ready     (sts_ready),
        .sts           (sts)
    );

endmodule

>>> sv/kcl_checker.sv
module kcl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sts_valid,
    input  logic              sts_ready,
    input  kcl_pkg::kcl_sts_t sts
);
    import kcl_pkg::*;

    // a waiting status stays up until taken
    a_sts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sts_valid && !sts_ready |=> sts_valid)
        else $error("status dropped before transfer");

    a_success: assert property (@(posedge clk) disable iff (!rst_n)
        sts_valid && sts.sound_event == SND_SUCCESS |->
            sts.lock_mode == LOCK_OPEN && sts.digit_count == 3'd0 && sts.refresh)
        else $error("success without open mode and cleared entry");

    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        sts_valid && sts.sound_event == SND_ERROR |->
            sts.lock_mode != LOCK_OPEN && sts.digit_count == 3'd0 && sts.refresh)
        else $error("error sound with wrong mode or entry");

    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        sts_valid && sts.sound_event == SND_CLOSE |->
            sts.lock_mode == LOCK_LOCKED && sts.refresh)
        else $error("close chirp without relock");

    a_alert: assert property (@(posedge clk) disable iff (!rst_n)
        sts_valid && sts.sound_event == SND_ALERT |->
            sts.lock_mode == LOCK_ALERT && !sts.refresh)
        else $error("alert beep outside alert mode");

endmodule

bind keypad_code_lock_with_door_sensor kcl_checker u_kcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts_valid (sts_valid),
    .sts_ready (sts_ready),
    .sts       (sts)
);

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int         CODE_LEN      = CODE_LEN_DEF;
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_LETTER_A  = 4'd12;
    localparam logic [3:0] KEY_LETTER_D  = 4'd15;
    localparam int         IDLE_PCT      = 21;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         RANDOM_ITEMS  = 1650;
    localparam int         RANDOM_PHASES = 8;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         EVT_W         = $bits(kcl_evt_t);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               evt_valid = 1'b0;
    logic               evt_ready;
    kcl_evt_t           evt       = '0;
    logic               sts_valid;
    logic               sts_ready = 1'b0;
    kcl_sts_t           sts;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bit idle_en     = 1'b1;
    int errors      = 0;
    int cycles      = 0;
    int live_events = 0;

    kcl_sts_t expected_status[$];

    // lock state as the block should hold it
    logic [SECRET_W-1:0] code_cfg  = SECRET_RST;
    logic [ECHO_W-1:0]   limit_cfg = LIMIT_RST;
    logic [1:0]          lock_q    = LOCK_LOCKED;
    logic [3:0]          entry_digits [CODE_LEN] = '{default: '0};
    int                  entry_count = 0;
    bit                  door_seen   = 1'b0;

    keypad_code_lock_with_door_sensor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .sts_valid (sts_valid),
        .sts_ready (sts_ready),
        .sts       (sts),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d status transfers outstanding", $time,
                     expected_status.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sts_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic predict_status(input kcl_evt_t e, output kcl_sts_t s);
        bit match;
        s = '0;
        s.sound_event = SND_NONE;
        if (e.opcode == OP_KEY)
        begin
            if (e.key_code <= KEY_DIGIT_MAX)
            begin
                if (entry_count < CODE_LEN)
                begin
                    entry_digits[entry_count] = e.key_code;
                    entry_count++;
                    s.refresh = 1'b1;
                end
            end
            else if (e.key_code == KEY_STAR)
            begin
                if (entry_count > 0)
                begin
                    entry_count--;
                    s.refresh = 1'b1;
                end
            end
            else if (e.key_code == KEY_HASH && lock_q != LOCK_OPEN)
            begin
                match = (entry_count == CODE_LEN);
                for (int i = 0; i < CODE_LEN; i++)
                    if (match && entry_digits[i] != code_cfg[4*(CODE_LEN-1-i) +: 4])
                        match = 1'b0;
                if (match)
                begin
                    lock_q = LOCK_OPEN;
                    s.sound_event = SND_SUCCESS;
                end
                else
                    s.sound_event = SND_ERROR;
                entry_count = 0;
                s.refresh = 1'b1;
            end
        end
        else if (e.echo_us != 0)
        begin
            case (lock_q)
                LOCK_LOCKED:
                    if (e.echo_us > limit_cfg)
                    begin
                        lock_q = LOCK_ALERT;
                        s.refresh = 1'b1;
                    end
                LOCK_OPEN:
                    if (e.echo_us > limit_cfg)
                    begin
                        if (!door_seen)
                        begin
                            door_seen = 1'b1;
                            s.refresh = 1'b1;
                        end
                    end
                    else if (door_seen)
                    begin
                        lock_q = LOCK_LOCKED;
                        door_seen = 1'b0;
                        s.sound_event = SND_CLOSE;
                        s.refresh = 1'b1;
                    end
                LOCK_ALERT:
                    s.sound_event = SND_ALERT;
                default: ;
            endcase
        end
        s.lock_mode   = lock_q;
        s.digit_count = 3'(entry_count);
    endtask

    function automatic void check_field(string name, int want, logic [2:0] got);
        if (got !== 3'(want))
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        kcl_sts_t want;
        if (rst_n && sts_valid && sts_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: status transfer with none expected, actual %p", $time, sts);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("lock_mode", want.lock_mode, {1'b0, sts.lock_mode});
                check_field("digit_count", want.digit_count, sts.digit_count);
                check_field("sound_event", want.sound_event, sts.sound_event);
                check_field("refresh", want.refresh, {2'b00, sts.refresh});
            end
        end
    end

    // called right after a rising edge; leaves valid high after the transfer
    task automatic send_event(input kcl_evt_t e);
        kcl_sts_t s;
        if (idle_en)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                evt_valid <= 1'b0;
                @(posedge clk);
            end
        evt_valid <= 1'b1;
        evt       <= e;
        do
            @(posedge clk);
        while (!evt_ready);
        predict_status(e, s);
        expected_status.push_back(s);
        if (!(e.opcode == OP_KEY && e.key_code >= KEY_LETTER_A) &&
            !(e.opcode == OP_ECHO && e.echo_us == 0))
            live_events++;
    endtask

    function automatic kcl_evt_t key_event(logic [3:0] k);
        kcl_evt_t e;
        e.opcode   = OP_KEY;
        e.key_code = k;
        e.echo_us  = ECHO_W'($urandom);
        return e;
    endfunction

    function automatic kcl_evt_t echo_event(logic [ECHO_W-1:0] us);
        kcl_evt_t e;
        e.opcode   = OP_ECHO;
        e.key_code = 4'($urandom);
        e.echo_us  = us;
        return e;
    endfunction

    function automatic logic [ECHO_W-1:0] door_echo(bit open);
        logic [ECHO_W-1:0] top;
        top = '1;
        if (open)
            return (limit_cfg == top) ? top : ECHO_W'($urandom_range(top, limit_cfg + 1));
        return (limit_cfg == 0) ? ECHO_W'(1) : ECHO_W'($urandom_range(limit_cfg, 1));
    endfunction

    task automatic settle();
        evt_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_SECRET)
            code_cfg = data[SECRET_W-1:0];
        else
            limit_cfg = data[ECHO_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [SECRET_W-1:0] code, input logic [ECHO_W-1:0] limit);
        settle();
        apb_write(REG_SECRET, PDATA_W'(code));
        apb_write(REG_LIMIT, PDATA_W'(limit));
    endtask

    task automatic enter_code(input bit scramble);
        logic [3:0] d;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            d = code_cfg[4*(CODE_LEN-1-i) +: 4];
            if (scramble || d > KEY_DIGIT_MAX)
                d = 4'($urandom_range(9));
            // typo corrected with star
            if ($urandom_range(99) < 10)
            begin
                send_event(key_event(4'($urandom_range(9))));
                send_event(key_event(KEY_STAR));
            end
            send_event(key_event(d));
        end
        if ($urandom_range(99) < 10)
            send_event(key_event(4'($urandom_range(9))));
        send_event(key_event(KEY_HASH));
    endtask

    task automatic test_key_entry();
        send_event(key_event(KEY_STAR));
        send_event(key_event(KEY_LETTER_A));
        send_event(key_event(KEY_LETTER_D));
        for (int i = 0; i < CODE_LEN; i++)
            send_event(key_event(code_cfg[4*(CODE_LEN-1-i) +: 4]));
        send_event(key_event(KEY_DIGIT_MAX));
        send_event(key_event(KEY_HASH));
        // hash is ignored while open, the digit stays
        send_event(key_event(4'd0));
        send_event(key_event(KEY_HASH));
        send_event(key_event(KEY_STAR));
    endtask

    task automatic test_door_sensor();
        send_event(echo_event('0));
        send_event(echo_event('1));
        send_event(echo_event('1));
        send_event(echo_event(limit_cfg));
        send_event(echo_event(ECHO_W'(limit_cfg + 1)));
        send_event(echo_event(ECHO_W'(1)));
        send_event(key_event(KEY_HASH));
    endtask

    task automatic run_phase(input int n);
        int goal;
        int roll;
        kcl_evt_t e;
        goal = live_events + n;
        while (live_events < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                enter_code($urandom_range(99) < 15);
            else if (roll < 75)
            begin
                repeat ($urandom_range(3, 1)) send_event(echo_event(door_echo(1'b1)));
                repeat ($urandom_range(3, 1)) send_event(echo_event(door_echo(1'b0)));
            end
            else
            begin
                e = kcl_evt_t'(EVT_W'($urandom));
                if ($urandom_range(99) < 10)
                    e.echo_us = '0;
                send_event(e);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [SECRET_W-1:0] code;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            code = SECRET_W'($urandom);
            if (p % 2 == 0)
                for (int i = 0; i < CODE_LEN; i++)
                    code[4*i +: 4] = 4'($urandom_range(9));
            case (p)
                0: configure('0, '0);
                1: configure(24'h999999, '1);
                2: configure('1, ECHO_W'(100));
                3: configure(SECRET_RST, LIMIT_RST);
                default: configure(code, ECHO_W'($urandom));
            endcase
            // one phase runs back to back with no idle cycles on either side
            idle_en = (p != 3);
            run_phase(RANDOM_ITEMS / RANDOM_PHASES);
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_key_entry();
        test_door_sensor();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
